// ----- rtl/odc_pkg.sv -----
// Shared types, codes and constants of the obstacle-avoiding drive controller.
package odc_pkg;

    // Widths of the distance compare and of the phase tick counter.
    localparam int DIST_BITS = 16;
    localparam int TICK_BITS = 8;
    localparam int LIMIT_BITS = 8;
    localparam int CMP_BITS = (TICK_BITS > LIMIT_BITS) ? TICK_BITS : LIMIT_BITS;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Configuration port.
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAFE_DISTANCE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_TICKS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKUP_TICKS = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_TICKS = 2'd3;

    localparam logic [15:0] RST_SAFE_DISTANCE = 16'd250;
    localparam logic [LIMIT_BITS-1:0] RST_STOP_TICKS = 8'd6;
    localparam logic [LIMIT_BITS-1:0] RST_BACKUP_TICKS = 8'd30;
    localparam logic [LIMIT_BITS-1:0] RST_TURN_TICKS = 8'd15;

    // Clamp limits and fixed wheel speeds.
    localparam logic [6:0] SPEED_MAX = 7'd100;
    localparam logic [7:0] SERVO_MAX = 8'd180;
    localparam logic signed [7:0] SPD_STEER = 8'sd50;
    localparam logic signed [7:0] SPD_BACK = 8'sd40;
    localparam logic signed [7:0] SPD_TURN_FAST = 8'sd60;
    localparam logic signed [7:0] SPD_TURN_SLOW = 8'sd40;

    // Safety sequencer states.
    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_STOP   = 4'b0010,
        MODE_BACKUP = 4'b0100,
        MODE_TURN   = 4'b1000
    } t_mode;

    localparam logic [1:0] CODE_NORMAL = 2'd0;
    localparam logic [1:0] CODE_STOP = 2'd1;
    localparam logic [1:0] CODE_BACKUP = 2'd2;
    localparam logic [1:0] CODE_TURN = 2'd3;

    // Motion command kinds.
    typedef enum logic [2:0] {
        CMD_F  = 3'd0,
        CMD_B  = 3'd1,
        CMD_L  = 3'd2,
        CMD_R  = 3'd3,
        CMD_SL = 3'd4,
        CMD_SR = 3'd5,
        CMD_S  = 3'd6,
        CMD_G  = 3'd7
    } t_cmd;

    // Event codes reported with every result.
    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_US_STOP    = 4'd1,
        EV_IR_BOTH    = 4'd2,
        EV_IR_LEFT    = 4'd3,
        EV_IR_RIGHT   = 4'd4,
        EV_BACK       = 4'd5,
        EV_TURN_LEFT  = 4'd6,
        EV_TURN_RIGHT = 4'd7,
        EV_RESUME     = 4'd8,
        EV_COMMAND    = 4'd9
    } t_event;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // One input item.
    typedef struct packed {
        logic                 action;
        t_cmd                 kind;
        logic signed [15:0]   value;
        logic                 obs_left;
        logic                 obs_right;
        logic [DIST_BITS-1:0] distance;
    } t_item;

    // One result item.
    typedef struct packed {
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
        logic [7:0]        servo_angle;
        logic [1:0]        safety_state;
        t_event            event_code;
    } t_result;

    // Configuration registers as seen by the sequencer.
    typedef struct packed {
        logic [15:0]           safe_distance;
        logic [LIMIT_BITS-1:0] stop_ticks;
        logic [LIMIT_BITS-1:0] backup_ticks;
        logic [LIMIT_BITS-1:0] turn_ticks;
    } t_cfg;

    // Encodes a sequencer state as its two-bit report code.
    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_NORMAL: c = CODE_NORMAL;
            MODE_STOP:   c = CODE_STOP;
            MODE_BACKUP: c = CODE_BACKUP;
            MODE_TURN:   c = CODE_TURN;
            default:     c = CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/obstacle_avoid_drive_controller.sv -----
// Top level of the obstacle-avoiding drive controller.
//
//  Channel  Direction  Handshake              Payload
//  input    in         i_valid / o_ready      action, command_kind, command_value,
//                                             obstacle_left, obstacle_right, distance_mm
//  result   out        o_valid / i_ready      left_speed, right_speed, servo_angle,
//                                             safety_state, event_code
//  config   in         i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// Each item passes from the input register to the result register, which the compute step
// writes; one item a cycle is sustained while the consumer takes every result.
// The compute step runs when the input register holds an item and the result
// register is empty or being taken; a stalled result holds the input register.
// Synchronous active-low reset empties both registers and restores the state
// and the configuration defaults.
module obstacle_avoid_drive_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [2:0]                          i_command_kind,
    input  logic signed [15:0]                  i_command_value,
    input  logic                                i_obstacle_left,
    input  logic                                i_obstacle_right,
    input  logic [15:0]                         i_distance_mm,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [7:0]                   o_left_speed,
    output logic signed [7:0]                   o_right_speed,
    output logic [7:0]                          o_servo_angle,
    output logic [1:0]                          o_safety_state,
    output logic [3:0]                          o_event_code,
    input  logic                                i_cfg_we,
    input  logic [odc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [odc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    odc_pkg::t_item   in_item;
    odc_pkg::t_item   held_item;
    logic             held_valid;
    logic             out_space;
    logic             fire;
    odc_pkg::t_result step_result;
    odc_pkg::t_result out_result;
    odc_pkg::t_cfg    r_cfg;

    // Pack the input ports into one item.
    assign in_item = '{
        action:    i_action,
        kind:      odc_pkg::t_cmd'(i_command_kind),
        value:     i_command_value,
        obs_left:  i_obstacle_left,
        obs_right: i_obstacle_right,
        distance:  i_distance_mm[odc_pkg::DIST_BITS-1:0]
    };

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.safe_distance <= odc_pkg::RST_SAFE_DISTANCE;
            r_cfg.stop_ticks <= odc_pkg::RST_STOP_TICKS;
            r_cfg.backup_ticks <= odc_pkg::RST_BACKUP_TICKS;
            r_cfg.turn_ticks <= odc_pkg::RST_TURN_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                odc_pkg::CFG_SAFE_DISTANCE: r_cfg.safe_distance <= i_cfg_data;
                odc_pkg::CFG_STOP_TICKS:
                    r_cfg.stop_ticks <= i_cfg_data[odc_pkg::LIMIT_BITS-1:0];
                odc_pkg::CFG_BACKUP_TICKS:
                    r_cfg.backup_ticks <= i_cfg_data[odc_pkg::LIMIT_BITS-1:0];
                odc_pkg::CFG_TURN_TICKS:
                    r_cfg.turn_ticks <= i_cfg_data[odc_pkg::LIMIT_BITS-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign fire = held_valid && out_space;

    odc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (fire),
        .o_item  (held_item)
    );

    odc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    odc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (step_result),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_left_speed = out_result.left_speed;
    assign o_right_speed = out_result.right_speed;
    assign o_servo_angle = out_result.servo_angle;
    assign o_safety_state = out_result.safety_state;
    assign o_event_code = out_result.event_code;

endmodule

// ----- rtl/odc_in_reg.sv -----
// Input register stage that holds one accepted item for the compute step.
module odc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  odc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output odc_pkg::t_item o_item
);

    logic           r_valid;
    odc_pkg::t_item r_item;

    // The stage refills in the same cycle that the compute step drains it.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload is loaded on every transfer and needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

endmodule

// ----- rtl/odc_core.sv -----
// Command decoder, safety sequencer and the drive state it updates.
module odc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  odc_pkg::t_item   i_item,
    input  odc_pkg::t_cfg    i_cfg,
    output odc_pkg::t_result o_result
);

    odc_pkg::t_mode                  r_mode, n_mode;
    logic [odc_pkg::TICK_BITS-1:0]   r_phase, n_phase;
    logic                            r_turn_left, n_turn_left;
    logic signed [7:0]               r_left, n_left;
    logic signed [7:0]               r_right, n_right;
    logic [7:0]                      r_servo, n_servo;
    odc_pkg::t_event                 n_event;

    logic [6:0]                      speed;
    logic [6:0]                      speed_inv;
    logic signed [7:0]               sp_pos;
    logic signed [7:0]               sp_neg;
    logic signed [7:0]               inv_pos;
    logic signed [7:0]               inv_neg;
    logic [7:0]                      angle;
    logic [odc_pkg::LIMIT_BITS-1:0]  limit;
    logic                            expired;
    logic [odc_pkg::TICK_BITS-1:0]   phase_inc;
    logic [odc_pkg::DIST_BITS-1:0]   safe_dist;
    logic                            near_echo;

    // Clamp the command value to the speed and servo ranges.
    always_comb begin
        if (i_item.value < 16'sd0) begin
            speed = 7'd0;
            angle = 8'd0;
        end else begin
            speed = (i_item.value > $signed({9'd0, odc_pkg::SPEED_MAX}))
                    ? odc_pkg::SPEED_MAX : i_item.value[6:0];
            angle = (i_item.value > $signed({8'd0, odc_pkg::SERVO_MAX}))
                    ? odc_pkg::SERVO_MAX : i_item.value[7:0];
        end
        speed_inv = odc_pkg::SPEED_MAX - speed;
        sp_pos = $signed({1'b0, speed});
        sp_neg = 8'sd0 - sp_pos;
        inv_pos = $signed({1'b0, speed_inv});
        inv_neg = 8'sd0 - inv_pos;
    end

    // Tick limit of the current phase and the saturating count.
    always_comb begin
        case (r_mode)
            odc_pkg::MODE_STOP:   limit = i_cfg.stop_ticks;
            odc_pkg::MODE_BACKUP: limit = i_cfg.backup_ticks;
            default:              limit = i_cfg.turn_ticks;
        endcase
        expired = odc_pkg::CMP_BITS'(r_phase) > odc_pkg::CMP_BITS'(limit);
        phase_inc = (r_phase < odc_pkg::TICK_MAX) ? r_phase + 1'b1 : r_phase;
        safe_dist = i_cfg.safe_distance[odc_pkg::DIST_BITS-1:0];
        near_echo = (i_item.distance != '0) && (i_item.distance < safe_dist);
    end

    // Next state and event for one item.
    always_comb begin
        n_mode = r_mode;
        n_phase = r_phase;
        n_turn_left = r_turn_left;
        n_left = r_left;
        n_right = r_right;
        n_servo = r_servo;
        n_event = odc_pkg::EV_NONE;
        if (i_item.action == odc_pkg::ACT_COMMAND) begin
            n_event = odc_pkg::EV_COMMAND;
            case (i_item.kind)
                odc_pkg::CMD_F: begin
                    n_left = sp_neg;
                    n_right = sp_pos;
                end
                odc_pkg::CMD_B: begin
                    n_left = inv_pos;
                    n_right = inv_neg;
                end
                odc_pkg::CMD_L: begin
                    n_left = 8'sd0;
                    n_right = sp_pos;
                end
                odc_pkg::CMD_R: begin
                    n_left = sp_neg;
                    n_right = 8'sd0;
                end
                odc_pkg::CMD_SL: begin
                    n_left = sp_pos;
                    n_right = inv_pos;
                end
                odc_pkg::CMD_SR: begin
                    n_left = inv_neg;
                    n_right = sp_neg;
                end
                odc_pkg::CMD_S: begin
                    n_left = 8'sd0;
                    n_right = 8'sd0;
                end
                default: begin
                    n_servo = angle;
                end
            endcase
        end else begin
            case (r_mode)
                odc_pkg::MODE_NORMAL: begin
                    if (near_echo) begin
                        n_mode = odc_pkg::MODE_STOP;
                        n_phase = '0;
                        n_left = 8'sd0;
                        n_right = 8'sd0;
                        n_event = odc_pkg::EV_US_STOP;
                    end else if (i_item.obs_left && i_item.obs_right) begin
                        n_mode = odc_pkg::MODE_STOP;
                        n_phase = '0;
                        n_turn_left = 1'b1;
                        n_left = 8'sd0;
                        n_right = 8'sd0;
                        n_event = odc_pkg::EV_IR_BOTH;
                    end else if (i_item.obs_left) begin
                        n_left = 8'sd0 - odc_pkg::SPD_STEER;
                        n_right = 8'sd0;
                        n_event = odc_pkg::EV_IR_LEFT;
                    end else if (i_item.obs_right) begin
                        n_left = 8'sd0;
                        n_right = odc_pkg::SPD_STEER;
                        n_event = odc_pkg::EV_IR_RIGHT;
                    end
                end
                odc_pkg::MODE_STOP: begin
                    n_phase = phase_inc;
                    if (expired) begin
                        n_mode = odc_pkg::MODE_BACKUP;
                        n_phase = '0;
                        n_left = odc_pkg::SPD_BACK;
                        n_right = 8'sd0 - odc_pkg::SPD_BACK;
                        n_event = odc_pkg::EV_BACK;
                    end
                end
                odc_pkg::MODE_BACKUP: begin
                    n_phase = phase_inc;
                    if (expired) begin
                        n_mode = odc_pkg::MODE_TURN;
                        n_phase = '0;
                        if (!i_item.obs_left && i_item.obs_right) begin
                            n_turn_left = 1'b0;
                            n_left = 8'sd0 - odc_pkg::SPD_TURN_SLOW;
                            n_right = 8'sd0 - odc_pkg::SPD_TURN_FAST;
                            n_event = odc_pkg::EV_TURN_RIGHT;
                        end else begin
                            n_turn_left = 1'b1;
                            n_left = odc_pkg::SPD_TURN_FAST;
                            n_right = odc_pkg::SPD_TURN_SLOW;
                            n_event = odc_pkg::EV_TURN_LEFT;
                        end
                    end
                end
                default: begin
                    n_phase = phase_inc;
                    if (expired) begin
                        n_mode = odc_pkg::MODE_NORMAL;
                        n_phase = '0;
                        n_event = odc_pkg::EV_RESUME;
                    end
                end
            endcase
        end
    end

    // State advances once per transfer into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= odc_pkg::MODE_NORMAL;
            r_phase <= '0;
            r_turn_left <= 1'b1;
            r_left <= 8'sd0;
            r_right <= 8'sd0;
            r_servo <= 8'd0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_phase <= n_phase;
            r_turn_left <= n_turn_left;
            r_left <= n_left;
            r_right <= n_right;
            r_servo <= n_servo;
        end
    end

    assign o_result = '{
        left_speed:   n_left,
        right_speed:  n_right,
        servo_angle:  n_servo,
        safety_state: odc_pkg::mode_code(n_mode),
        event_code:   n_event
    };

    // A command never moves the sequencer.
    a_cmd_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == odc_pkg::ACT_COMMAND |=> r_mode == $past(r_mode))
        else $error("command item changed the safety state");

    // A right turn records the turn direction.
    a_turn_right_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_event == odc_pkg::EV_TURN_RIGHT |=> !r_turn_left)
        else $error("right turn did not clear the turn direction");

    // Every state change restarts the phase count.
    a_phase_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_mode != r_mode |=> r_phase == '0)
        else $error("phase count not cleared on a state change");

    // The servo only moves on a servo command.
    a_servo_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !(i_item.action == odc_pkg::ACT_COMMAND && i_item.kind == odc_pkg::CMD_G)
        |=> r_servo == $past(r_servo))
        else $error("servo angle changed without a servo command");

endmodule

// ----- rtl/odc_out_reg.sv -----
// Result register that holds one result until the consumer takes it.
module odc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  odc_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output odc_pkg::t_result o_result
);

    logic             r_valid;
    odc_pkg::t_result r_result;

    // A new result may enter while the held one leaves.
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_result = r_result;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the obstacle-avoiding drive controller.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;

    // Clock, reset and the ports of the block.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic in_action = 1'b0;
    logic [2:0] in_kind = '0;
    logic signed [15:0] in_value = '0;
    logic in_obs_left = 1'b0;
    logic in_obs_right = 1'b0;
    logic [15:0] in_distance = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [7:0] out_left;
    logic signed [7:0] out_right;
    logic [7:0] out_servo;
    logic [1:0] out_state;
    logic [3:0] out_event;
    logic cfg_we = 1'b0;
    logic [odc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [odc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    // Stimulus and scoreboard.
    odc_pkg::t_item queued_requests[$];
    odc_pkg::t_result expected_drive[$];
    int requests_queued = 0;
    int results_checked = 0;
    int error_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    // Predicted configuration.
    logic [15:0] safe_limit = odc_pkg::RST_SAFE_DISTANCE;
    logic [odc_pkg::LIMIT_BITS-1:0] stop_limit = odc_pkg::RST_STOP_TICKS;
    logic [odc_pkg::LIMIT_BITS-1:0] backup_limit = odc_pkg::RST_BACKUP_TICKS;
    logic [odc_pkg::LIMIT_BITS-1:0] turn_limit = odc_pkg::RST_TURN_TICKS;

    // Predicted state of the controller.
    logic [1:0] seq_state = odc_pkg::CODE_NORMAL;
    logic [odc_pkg::TICK_BITS-1:0] phase_count = '0;
    logic signed [7:0] left_drive = '0;
    logic signed [7:0] right_drive = '0;
    logic [7:0] servo_pos = '0;

    // Coverage tallies for the summary.
    int n_commands = 0;
    int n_ticks = 0;
    int n_settings = 0;
    int n_us_stops = 0;
    int n_ir_stops = 0;
    int n_right_turns = 0;
    int n_resumes = 0;

    obstacle_avoid_drive_controller uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_action         (in_action),
        .i_command_kind   (in_kind),
        .i_command_value  (in_value),
        .i_obstacle_left  (in_obs_left),
        .i_obstacle_right (in_obs_right),
        .i_distance_mm    (in_distance),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_left_speed     (out_left),
        .o_right_speed    (out_right),
        .o_servo_angle    (out_servo),
        .o_safety_state   (out_state),
        .o_event_code     (out_event),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // Free-running clock.
    always #4 clk = ~clk;

    // Clamps a requested value into 0..hi.
    function automatic int clamp_to(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void set_drive(input int l, input int r);
        left_drive = 8'(l);
        right_drive = 8'(r);
    endfunction

    // Tests the phase count against a limit, then counts up with saturation.
    function automatic bit phase_expired(input logic [odc_pkg::LIMIT_BITS-1:0] limit);
        bit done;
        done = (odc_pkg::CMP_BITS'(phase_count) > odc_pkg::CMP_BITS'(limit));
        if (phase_count != odc_pkg::TICK_MAX) phase_count++;
        return done;
    endfunction

    // Computes the wheel, servo and sequencer outputs caused by one item.
    function automatic void predict_drive_step(input odc_pkg::t_item it);
        odc_pkg::t_result res;
        odc_pkg::t_event ev;
        int val;
        int spd;
        ev = odc_pkg::EV_NONE;
        if (it.action == odc_pkg::ACT_COMMAND) begin
            n_commands++;
            val = $signed(it.value);
            spd = clamp_to(val, 100);
            case (it.kind)
                odc_pkg::CMD_F:  set_drive(-spd, spd);
                odc_pkg::CMD_B:  set_drive(100 - spd, -(100 - spd));
                odc_pkg::CMD_L:  set_drive(0, spd);
                odc_pkg::CMD_R:  set_drive(-spd, 0);
                odc_pkg::CMD_SL: set_drive(spd, 100 - spd);
                odc_pkg::CMD_SR: set_drive(-(100 - spd), -spd);
                odc_pkg::CMD_S:  set_drive(0, 0);
                default: servo_pos = 8'(clamp_to(val, 180));
            endcase
            ev = odc_pkg::EV_COMMAND;
        end else begin
            n_ticks++;
            case (seq_state)
                odc_pkg::CODE_NORMAL: begin
                    if (it.distance != 0 && it.distance < safe_limit) begin
                        seq_state = odc_pkg::CODE_STOP;
                        phase_count = '0;
                        set_drive(0, 0);
                        ev = odc_pkg::EV_US_STOP;
                        n_us_stops++;
                    end else if (it.obs_left && it.obs_right) begin
                        seq_state = odc_pkg::CODE_STOP;
                        phase_count = '0;
                        set_drive(0, 0);
                        ev = odc_pkg::EV_IR_BOTH;
                        n_ir_stops++;
                    end else if (it.obs_left) begin
                        set_drive(-50, 0);
                        ev = odc_pkg::EV_IR_LEFT;
                    end else if (it.obs_right) begin
                        set_drive(0, 50);
                        ev = odc_pkg::EV_IR_RIGHT;
                    end
                end
                odc_pkg::CODE_STOP: begin
                    if (phase_expired(stop_limit)) begin
                        seq_state = odc_pkg::CODE_BACKUP;
                        phase_count = '0;
                        set_drive(40, -40);
                        ev = odc_pkg::EV_BACK;
                    end
                end
                odc_pkg::CODE_BACKUP: begin
                    if (phase_expired(backup_limit)) begin
                        seq_state = odc_pkg::CODE_TURN;
                        phase_count = '0;
                        if (!it.obs_left && it.obs_right) begin
                            set_drive(-40, -60);
                            ev = odc_pkg::EV_TURN_RIGHT;
                            n_right_turns++;
                        end else begin
                            set_drive(60, 40);
                            ev = odc_pkg::EV_TURN_LEFT;
                        end
                    end
                end
                default: begin
                    if (phase_expired(turn_limit)) begin
                        seq_state = odc_pkg::CODE_NORMAL;
                        phase_count = '0;
                        ev = odc_pkg::EV_RESUME;
                        n_resumes++;
                    end
                end
            endcase
        end
        res.left_speed = left_drive;
        res.right_speed = right_drive;
        res.servo_angle = servo_pos;
        res.safety_state = seq_state;
        res.event_code = ev;
        expected_drive.push_back(res);
    endfunction

    // Reports one wrong output field.
    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        error_count++;
    endtask

    function automatic odc_pkg::t_item make_item(input logic act, input odc_pkg::t_cmd kind,
                                                 input logic signed [15:0] value,
                                                 input logic ol, input logic orr,
                                                 input logic [15:0] dist_mm);
        odc_pkg::t_item it;
        it.action = act;
        it.kind = kind;
        it.value = value;
        it.obs_left = ol;
        it.obs_right = orr;
        it.distance = dist_mm;
        return it;
    endfunction

    // Random item: mostly ticks, with distances gathered around the stop limit.
    function automatic odc_pkg::t_item random_item();
        odc_pkg::t_item it;
        int pick;
        it.action = ($urandom_range(99) >= 15) ? odc_pkg::ACT_TICK : odc_pkg::ACT_COMMAND;
        it.kind = odc_pkg::t_cmd'($urandom_range(7));
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: it.value = 16'($urandom_range(100));
            3:       it.value = 16'($urandom_range(200, 101));
            4: begin
                case ($urandom_range(5))
                    0: it.value = 16'sd0;
                    1: it.value = 16'sd100;
                    2: it.value = 16'sd101;
                    3: it.value = 16'sd180;
                    4: it.value = 16'sd181;
                    default: it.value = -16'sd1;
                endcase
            end
            5, 6:    it.value = 16'($urandom);
            7:       it.value = -16'($urandom_range(200, 1));
            8:       it.value = 16'sh8000;
            default: it.value = 16'sh7FFF;
        endcase
        it.obs_left = ($urandom_range(3) == 0);
        it.obs_right = ($urandom_range(3) == 0);
        pick = $urandom_range(9);
        case (pick)
            0, 1: it.distance = '0;
            2:    it.distance = (safe_limit > 1) ? 16'($urandom_range(safe_limit - 1, 1))
                                                 : 16'd1;
            3:    it.distance = safe_limit + 16'($urandom_range(2)) - 16'd1;
            default: it.distance = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic queue_item(input odc_pkg::t_item it);
        queued_requests.push_back(it);
        requests_queued++;
    endtask

    // Waits until every queued item has produced its checked result.
    task automatic wait_drained();
        while (results_checked < requests_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers while the block is idle.
    task automatic set_config(input logic [15:0] safe, input logic [15:0] stop_t,
                              input logic [15:0] back_t, input logic [15:0] turn_t);
        logic [15:0] data [4];
        data = '{safe, stop_t, back_t, turn_t};
        for (int i = 0; i < 4; i++) begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= odc_pkg::CFG_INDEX_BITS'(i);
            cfg_data <= data[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        safe_limit = safe;
        stop_limit = stop_t[odc_pkg::LIMIT_BITS-1:0];
        backup_limit = back_t[odc_pkg::LIMIT_BITS-1:0];
        turn_limit = turn_t[odc_pkg::LIMIT_BITS-1:0];
        n_settings++;
    endtask

    // Runs one phase of random items under one idling pattern.
    task automatic run_phase(input int pattern, input int count);
        case (pattern)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
        endcase
        repeat (count) queue_item(random_item());
        wait_drained();
    endtask

    // Input driver: presents queued items and predicts each transfer.
    always @(posedge clk) begin : request_driver
        odc_pkg::t_item it;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_drive_step(make_item(in_action, odc_pkg::t_cmd'(in_kind), in_value,
                                             in_obs_left, in_obs_right, in_distance));
            end
            if (!in_valid || in_ready) begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    it = queued_requests.pop_front();
                    in_action <= it.action;
                    in_kind <= it.kind;
                    in_value <= it.value;
                    in_obs_left <= it.obs_left;
                    in_obs_right <= it.obs_right;
                    in_distance <= it.distance;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each transfer with the oldest expectation.
    always @(posedge clk) begin : result_monitor
        odc_pkg::t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_drive.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d %0d",
                             $time, out_left, out_right, out_servo, out_state, out_event);
                    error_count++;
                end else begin
                    want = expected_drive.pop_front();
                    results_checked++;
                    if (out_left !== want.left_speed)
                        report_field("left_speed", want.left_speed, out_left);
                    if (out_right !== want.right_speed)
                        report_field("right_speed", want.right_speed, out_right);
                    if (out_servo !== want.servo_angle)
                        report_field("servo_angle", want.servo_angle, out_servo);
                    if (out_state !== want.safety_state)
                        report_field("safety_state", want.safety_state, out_state);
                    if (out_event !== want.event_code)
                        report_field("event_code", want.event_code, out_event);
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset configuration.
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_F, 16'sh8000,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_F, 16'sh7FFF,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_B, 16'sd0,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_B, 16'sd60,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_L, 16'sd100,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_R, 16'sd101,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_SL, 16'sd30,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_SR, -16'sd5,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_SR, 16'sd100,
                             1'b0, 1'b0, 16'd0));
        // A stop command ignores its value; command items ignore the sensors.
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_S, 16'sd1234,
                             1'b1, 1'b1, 16'd5));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_G, 16'sd180,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_G, 16'sd181,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_G, -16'sd1,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_G, 16'sd90,
                             1'b0, 1'b0, 16'd0));
        // Ticks: no echo, distance at the limit, one-sided hits, near echo.
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_G, 16'sd77,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_F, 16'sd0,
                             1'b0, 1'b0, 16'd250));
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_B, 16'sd0,
                             1'b1, 1'b0, 16'hFFFF));
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_L, 16'sd0,
                             1'b0, 1'b1, 16'd0));
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_R, 16'sd0,
                             1'b1, 1'b1, 16'd249));
        // A command during the escape sequence sets speeds, the state holds.
        queue_item(make_item(odc_pkg::ACT_COMMAND, odc_pkg::CMD_F, 16'sd20,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_F, 16'sd0,
                             1'b0, 1'b0, 16'd0));
        queue_item(make_item(odc_pkg::ACT_TICK, odc_pkg::CMD_F, 16'sd0,
                             1'b1, 1'b1, 16'd10));
        run_phase(0, 300);

        // Largest stop distance, escape phase limits of zero.
        set_config(16'hFFFF, 16'd0, 16'd0, 16'd0);
        run_phase(1, 300);

        // No echo stop, limits at the counter maximum hold the state.
        set_config(16'd0, 16'hA5FF, 16'h5AFF, 16'hFFFF);
        run_phase(2, 150);

        // Stop limit just under the counter maximum releases the hold.
        set_config(16'd1000, 16'd254, 16'd3, 16'd2);
        run_phase(3, 350);

        set_config(16'($urandom_range(2000)), {8'($urandom), 8'($urandom_range(12))},
                   {8'($urandom), 8'($urandom_range(12))},
                   {8'($urandom), 8'($urandom_range(12))});
        run_phase(0, 300);

        set_config(16'($urandom_range(600)), {8'($urandom), 8'($urandom_range(20))},
                   {8'($urandom), 8'($urandom_range(20))},
                   {8'($urandom), 8'($urandom_range(20))});
        run_phase(1, 300);

        if (expected_drive.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_drive.size());
            error_count++;
        end
        $display("Covered %0d commands and %0d ticks under %0d register settings, %0d errors.",
                 n_commands, n_ticks, n_settings + 1, error_count);
        $display("Escapes: %0d echo stops, %0d IR stops, %0d right turns, %0d resumes.",
                 n_us_stops, n_ir_stops, n_right_turns, n_resumes);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- obstacle_avoid_drive_controller.f -----
rtl/odc_pkg.sv
rtl/odc_in_reg.sv
rtl/odc_core.sv
rtl/odc_out_reg.sv
rtl/obstacle_avoid_drive_controller.sv
tb/testbench.sv
